// ===== src/clb_pkg.sv =====
// shared types and constants of the cursor line edit buffer
// used by the channel interfaces, the generic ram and the top level
`default_nettype none

package clb_pkg;

   localparam int unsigned BUFFER_DEPTH_DEF = 1024;

   localparam int unsigned CMD_W       = 3;
   localparam int unsigned CHAR_W      = 8;
   localparam int unsigned INDEX_W     = 10;
   localparam int unsigned COUNT_OUT_W = 11;
   localparam int unsigned STATUS_W    = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 3'd0,
      CMD_LEFT   = 3'd1,
      CMD_RIGHT  = 3'd2,
      CMD_BACK   = 3'd3,
      CMD_READ   = 3'd4
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_DONE     = 2'd0,
      STS_BOUNDARY = 2'd1,
      STS_FULL     = 2'd2,
      STS_RANGE    = 2'd3
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

endpackage

`default_nettype wire

// ===== src/clb_if.sv =====
// valid/ready channel interfaces for command and result transactions
// depends on clb_pkg for the field widths
`default_nettype none

interface clb_req_if;
   import clb_pkg::*;

   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   cmd;
   logic [CHAR_W-1:0]  char_in;
   logic [INDEX_W-1:0] read_index;

   modport source (output valid, output cmd, output char_in, output read_index, input ready);
   modport sink   (input valid, input cmd, input char_in, input read_index, output ready);
endinterface

interface clb_rsp_if;
   import clb_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CHAR_W-1:0]      char_out;
   logic [COUNT_OUT_W-1:0] text_length;
   logic [COUNT_OUT_W-1:0] cursor_pos;
   logic [STATUS_W-1:0]    status;

   modport source (output valid, output char_out, output text_length, output cursor_pos,
                   output status, input ready);
   modport sink   (input valid, input char_out, input text_length, input cursor_pos,
                   input status, output ready);
endinterface

`default_nettype wire

// ===== src/clb_ram.sv =====
// generic single-write single-read ram with registered read data
// parameter defaults come from clb_pkg
`default_nettype none

module clb_ram #(
   parameter int unsigned WIDTH = clb_pkg::CHAR_W,
   parameter int unsigned DEPTH = clb_pkg::BUFFER_DEPTH_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== src/cursor_line_edit_buffer.sv =====
// gap buffer line editor: before-cursor stack and reversed after-cursor stack in two rams
// the result is registered when the execute state fires, which waits while an earlier result is stalled
// a new command is taken only in the idle state, after the ram read and the write-back of the last one
// a waiting result sits in the output register while the next command is taken
// reset: synchronous, clears both stack counts and the controller; the stores are not
// initialized and need no clearing pass, entries are only read below the stack counts
`default_nettype none

module cursor_line_edit_buffer #(
   parameter int unsigned BUFFER_DEPTH = clb_pkg::BUFFER_DEPTH_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   clb_req_if.sink   req,
   clb_rsp_if.source rsp
);
   import clb_pkg::*;

   localparam int unsigned AW = $clog2(BUFFER_DEPTH);
   localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1);
   localparam int unsigned W  = ((CW > INDEX_W) ? CW : INDEX_W) + 1;

   state_type state_ff, state_in;
   logic [CW-1:0] bc_ff, bc_in;
   logic [CW-1:0] ac_ff, ac_in;

   cmd_type            cmd_ff;
   logic [CHAR_W-1:0]  char_ff;
   logic [INDEX_W-1:0] idx_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]      char_out_ff, char_out_in;
   logic [COUNT_OUT_W-1:0] len_out_ff, len_out_in;
   logic [COUNT_OUT_W-1:0] cur_out_ff, cur_out_in;
   status_type             status_ff, status_in;

   logic              b_wr_en, a_wr_en, rd_en;
   logic [AW-1:0]     b_wr_addr, a_wr_addr, b_rd_addr, a_rd_addr;
   logic [CHAR_W-1:0] b_wr_data, a_wr_data, b_rd_data, a_rd_data;

   logic    accept, fire;
   cmd_type req_cmd;
   logic [W-1:0] bc_w, ac_w, len_w, bc_dec_w, ac_dec_w, req_idx_w, pos_w, idx_w, len_new_w;

   assign accept  = req.valid && req.ready;
   assign req_cmd = cmd_type'(req.cmd);

   assign bc_w      = W'(bc_ff);
   assign ac_w      = W'(ac_ff);
   assign len_w     = bc_w + ac_w;
   assign bc_dec_w  = bc_w - W'(1);
   assign ac_dec_w  = ac_w - W'(1);
   assign req_idx_w = W'(req.read_index);
   // after stack is reversed: text index i right of the cursor sits at length-1-i
   assign pos_w     = len_w - W'(1) - req_idx_w;
   assign idx_w     = W'(idx_ff);

   // read addresses come straight from the command so data is ready in the exec cycle
   assign rd_en     = accept;
   assign b_rd_addr = (req_cmd == CMD_LEFT)  ? bc_dec_w[AW-1:0] : req_idx_w[AW-1:0];
   assign a_rd_addr = (req_cmd == CMD_RIGHT) ? ac_dec_w[AW-1:0] : pos_w[AW-1:0];

   assign fire = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (fire) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req.ready = (state_ff == ST_IDLE);

   // execute and write back; counts are unchanged since the reads were issued
   always_comb begin
      bc_in       = bc_ff;
      ac_in       = ac_ff;
      b_wr_en     = 1'b0;
      a_wr_en     = 1'b0;
      b_wr_addr   = bc_ff[AW-1:0];
      a_wr_addr   = ac_ff[AW-1:0];
      b_wr_data   = char_ff;
      a_wr_data   = b_rd_data;
      char_out_in = '0;
      status_in   = STS_DONE;
      case (cmd_ff)
         CMD_INSERT: begin
            if (len_w >= W'(BUFFER_DEPTH)) begin
               status_in = STS_FULL;
            end else begin
               b_wr_en = fire;
               bc_in   = bc_ff + CW'(1);
            end
         end
         CMD_LEFT: begin
            if (bc_ff == '0 || ac_w >= W'(BUFFER_DEPTH)) begin
               status_in = STS_BOUNDARY;
            end else begin
               a_wr_en = fire;
               bc_in   = bc_ff - CW'(1);
               ac_in   = ac_ff + CW'(1);
            end
         end
         CMD_RIGHT: begin
            b_wr_data = a_rd_data;
            if (ac_ff == '0 || bc_w >= W'(BUFFER_DEPTH)) begin
               status_in = STS_BOUNDARY;
            end else begin
               b_wr_en = fire;
               ac_in   = ac_ff - CW'(1);
               bc_in   = bc_ff + CW'(1);
            end
         end
         CMD_BACK: begin
            if (bc_ff == '0) begin
               status_in = STS_BOUNDARY;
            end else begin
               bc_in = bc_ff - CW'(1);
            end
         end
         CMD_READ: begin
            if (idx_w >= len_w) begin
               status_in = STS_RANGE;
            end else if (idx_w < bc_w) begin
               char_out_in = b_rd_data;
            end else begin
               char_out_in = a_rd_data;
            end
         end
         default: status_in = STS_BOUNDARY;
      endcase
      if (!fire) begin
         bc_in = bc_ff;
         ac_in = ac_ff;
      end
   end

   assign len_new_w  = W'(bc_in) + W'(ac_in);
   assign len_out_in = len_new_w[COUNT_OUT_W-1:0];
   assign cur_out_in = COUNT_OUT_W'(W'(bc_in));

   always_comb begin
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bc_ff        <= '0;
         ac_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bc_ff        <= bc_in;
         ac_ff        <= ac_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_cmd;
         char_ff <= req.char_in;
         idx_ff  <= req.read_index;
      end
      if (fire) begin
         char_out_ff <= char_out_in;
         len_out_ff  <= len_out_in;
         cur_out_ff  <= cur_out_in;
         status_ff   <= status_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.char_out    = char_out_ff;
   assign rsp.text_length = len_out_ff;
   assign rsp.cursor_pos  = cur_out_ff;
   assign rsp.status      = status_ff;

   clb_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (BUFFER_DEPTH)
   ) u_before_ram (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (b_wr_addr),
      .wr_data (b_wr_data),
      .rd_en   (rd_en),
      .rd_addr (b_rd_addr),
      .rd_data (b_rd_data)
   );

   clb_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (BUFFER_DEPTH)
   ) u_after_ram (
      .clock   (clock),
      .wr_en   (a_wr_en),
      .wr_addr (a_wr_addr),
      .wr_data (a_wr_data),
      .rd_en   (rd_en),
      .rd_addr (a_rd_addr),
      .rd_data (a_rd_data)
   );

   // text never grows past the buffer depth
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_w <= W'(BUFFER_DEPTH))
      else $error("text length exceeds buffer depth");

   // an accepted command always moves to the execute cycle
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_EXEC))
      else $error("accepted command did not enter execute");

   // a new result only appears right after an execute cycle
   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(rsp_valid_ff)) |-> $past(state_ff == ST_EXEC))
      else $error("result raised without an execute cycle");

   // stack counts change only on write-back
   a_count_update: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (!$stable(bc_ff) || !$stable(ac_ff))) |-> $past(state_ff == ST_EXEC))
      else $error("stack count changed outside execute");

endmodule

`default_nettype wire

// ===== dv/line_edit_checker.sv =====
// result checker for the cursor line edit buffer: watches both channels, keeps its own gap buffer
// and compares every result transaction with the oldest predicted one; depends on clb_pkg, clb_if
`timescale 1ns / 1ps

module line_edit_checker (
   input  logic        clock,
   input  logic        reset,
   clb_req_if          req_bus,
   clb_rsp_if          rsp_bus,
   output int unsigned mismatch_count,
   output int unsigned outstanding
);
   import clb_pkg::*;

   localparam int unsigned DEPTH = BUFFER_DEPTH_DEF;

   typedef struct packed {
      logic [CHAR_W-1:0]      char_out;
      logic [COUNT_OUT_W-1:0] text_length;
      logic [COUNT_OUT_W-1:0] cursor_pos;
      status_type             status;
   } edit_result_type;

   // before_text holds text[0 .. cursor-1], after_text holds the rest reversed
   logic [CHAR_W-1:0] before_text [DEPTH];
   logic [CHAR_W-1:0] after_text  [DEPTH];
   int unsigned       before_len;
   int unsigned       after_len;

   edit_result_type   due_results [$];
   edit_result_type   want;
   int unsigned       fail_total;
   int unsigned       rsp_seen;

   function automatic edit_result_type apply_command(input logic [CMD_W-1:0] cmd,
                                                     input logic [CHAR_W-1:0] ch,
                                                     input logic [INDEX_W-1:0] idx);
      edit_result_type res;
      int unsigned     length;
      length         = before_len + after_len;
      res.char_out   = '0;
      res.status     = STS_DONE;
      case (cmd)
         CMD_INSERT: begin
            if (length >= DEPTH) begin
               res.status = STS_FULL;
            end else begin
               before_text[before_len] = ch;
               before_len++;
            end
         end
         CMD_LEFT: begin
            if (before_len == 0 || after_len >= DEPTH) begin
               res.status = STS_BOUNDARY;
            end else begin
               before_len--;
               after_text[after_len] = before_text[before_len];
               after_len++;
            end
         end
         CMD_RIGHT: begin
            if (after_len == 0 || before_len >= DEPTH) begin
               res.status = STS_BOUNDARY;
            end else begin
               after_len--;
               before_text[before_len] = after_text[after_len];
               before_len++;
            end
         end
         CMD_BACK: begin
            if (before_len == 0) begin
               res.status = STS_BOUNDARY;
            end else begin
               before_len--;
            end
         end
         CMD_READ: begin
            if (idx >= length) begin
               res.status = STS_RANGE;
            end else if (idx < before_len) begin
               res.char_out = before_text[idx];
            end else begin
               res.char_out = after_text[after_len - 1 - (idx - before_len)];
            end
         end
         default: begin
            res.status = STS_BOUNDARY;
         end
      endcase
      res.text_length = COUNT_OUT_W'(before_len + after_len);
      res.cursor_pos  = COUNT_OUT_W'(before_len);
      return res;
   endfunction

   task automatic report_mismatch(input string field, input logic [10:0] got,
                                  input logic [10:0] expected);
      fail_total++;
      $display("%0t line_edit_checker: result %0d %s got %0d expected %0d",
               $realtime, rsp_seen, field, got, expected);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         before_len = 0;
         after_len  = 0;
         fail_total = 0;
         rsp_seen   = 0;
         due_results.delete();
         mismatch_count <= 0;
         outstanding    <= 0;
      end else begin
         // a result accepted here always belongs to an earlier command
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (due_results.size() == 0) begin
               report_mismatch("with no command pending, status", 11'(rsp_bus.status), '0);
            end else begin
               want = due_results.pop_front();
               if (rsp_bus.char_out !== want.char_out)
                  report_mismatch("char_out", 11'(rsp_bus.char_out), 11'(want.char_out));
               if (rsp_bus.text_length !== want.text_length)
                  report_mismatch("text_length", rsp_bus.text_length, want.text_length);
               if (rsp_bus.cursor_pos !== want.cursor_pos)
                  report_mismatch("cursor_pos", rsp_bus.cursor_pos, want.cursor_pos);
               if (rsp_bus.status !== want.status)
                  report_mismatch("status", 11'(rsp_bus.status), 11'(want.status));
            end
            rsp_seen++;
         end
         if (req_bus.valid && req_bus.ready)
            due_results.push_back(apply_command(req_bus.cmd, req_bus.char_in,
                                                req_bus.read_index));
         mismatch_count <= fail_total;
         outstanding    <= due_results.size();
      end
   end

endmodule

// ===== dv/cursor_line_edit_buffer_tb.sv =====
// top of the cursor line edit buffer testbench: clock, reset, command stimulus, result stalls
// and the verdict; depends on clb_pkg, clb_if, the block and line_edit_checker
`timescale 1ns / 1ps

module cursor_line_edit_buffer_tb;
   import clb_pkg::*;

   localparam int unsigned IDLE_LIMIT = 5000;
   localparam int unsigned LONG_HOLD  = 300;

   // command codes with no defined operation
   localparam logic [CMD_W-1:0] CMD_UNDEF_FIRST = 3'd5;
   localparam logic [CMD_W-1:0] CMD_UNDEF_MID   = 3'd6;
   localparam logic [CMD_W-1:0] CMD_UNDEF_LAST  = 3'd7;

   logic        clock;
   logic        reset;
   int unsigned mismatch_count;
   int unsigned outstanding;
   int unsigned burst_left;
   bit          hold_due;

   clb_req_if req_bus ();
   clb_rsp_if rsp_bus ();

   cursor_line_edit_buffer DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   line_edit_checker edit_check (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // called at a falling edge, returns at the falling edge after the transaction
   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                            input logic [INDEX_W-1:0] idx);
      if (burst_left == 0) begin
         req_bus.valid <= 1'b0;
         repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 4))
            @(negedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
      end
      req_bus.valid      <= 1'b1;
      req_bus.cmd        <= cmd;
      req_bus.char_in    <= ch;
      req_bus.read_index <= idx;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      burst_left--;
   endtask

   // weights in percent, whatever is left over goes to undefined command codes
   task automatic send_random(input int w_ins, input int w_left, input int w_right,
                              input int w_back, input int w_read, input bit wide_index);
      int                 pick;
      logic [CMD_W-1:0]   cmd;
      logic [INDEX_W-1:0] idx;
      pick = $urandom_range(0, 99);
      if (pick < w_ins)
         cmd = CMD_INSERT;
      else if (pick < w_ins + w_left)
         cmd = CMD_LEFT;
      else if (pick < w_ins + w_left + w_right)
         cmd = CMD_RIGHT;
      else if (pick < w_ins + w_left + w_right + w_back)
         cmd = CMD_BACK;
      else if (pick < w_ins + w_left + w_right + w_back + w_read)
         cmd = CMD_READ;
      else
         cmd = CMD_W'($urandom_range(CMD_UNDEF_FIRST, CMD_UNDEF_LAST));
      idx = (wide_index || $urandom_range(0, 1)) ? INDEX_W'($urandom_range(0, 1023))
                                                 : INDEX_W'($urandom_range(0, 31));
      send_item(cmd, CHAR_W'($urandom_range(0, 255)), idx);
   endtask

   // result side stalls in stretches of changing duty, plus the long hold on request
   initial begin : receiver
      int mode;
      int span;
      rsp_bus.ready = 1'b0;
      forever begin
         if (hold_due) begin
            hold_due = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end
         mode = $urandom_range(0, 3);
         span = $urandom_range(5, 60);
         repeat (span) begin
            case (mode)
               0:       rsp_bus.ready <= 1'b1;
               1:       rsp_bus.ready <= 1'($urandom_range(0, 1));
               2:       rsp_bus.ready <= ($urandom_range(0, 7) != 0);
               default: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
            endcase
            @(negedge clock);
         end
      end
   end

   initial begin : watchdog
      int unsigned idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle = 0;
         else
            idle++;
      end
      $display("cursor_line_edit_buffer_tb: FAIL");
      $finish;
   end

   initial begin
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.cmd        = CMD_INSERT;
      req_bus.char_in    = '0;
      req_bus.read_index = '0;
      burst_left         = 0;
      hold_due           = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty buffer: every boundary case and the undefined codes, then inserts and reads in and past the text
      send_item(CMD_READ,        8'h00, 10'd0);
      send_item(CMD_LEFT,        8'h00, 10'd0);
      send_item(CMD_BACK,        8'h00, 10'd0);
      send_item(CMD_RIGHT,       8'h00, 10'd0);
      send_item(CMD_UNDEF_FIRST, 8'hff, 10'd1023);
      send_item(CMD_UNDEF_MID,   8'h00, 10'd0);
      send_item(CMD_UNDEF_LAST,  8'hff, 10'd1023);
      send_item(CMD_INSERT,      8'h00, 10'd0);
      send_item(CMD_INSERT,      8'hff, 10'd1023);
      send_item(CMD_INSERT,      8'h5a, 10'd0);
      send_item(CMD_INSERT,      8'ha5, 10'd0);
      send_item(CMD_READ,        8'h00, 10'd0);
      send_item(CMD_READ,        8'h00, 10'd3);
      send_item(CMD_READ,        8'h00, 10'd4);
      send_item(CMD_READ,        8'h00, 10'd1023);
      send_item(CMD_RIGHT,       8'h00, 10'd0);
      // step into the text so reads hit the reversed half
      send_item(CMD_LEFT,        8'h00, 10'd0);
      send_item(CMD_LEFT,        8'h00, 10'd0);
      send_item(CMD_READ,        8'h00, 10'd2);
      send_item(CMD_READ,        8'h00, 10'd3);
      send_item(CMD_INSERT,      8'h7e, 10'd0);
      send_item(CMD_BACK,        8'h00, 10'd0);
      send_item(CMD_BACK,        8'h00, 10'd0);
      send_item(CMD_RIGHT,       8'h00, 10'd0);
      send_item(CMD_READ,        8'h00, 10'd1);

      repeat (400) send_random(35, 15, 15, 10, 20, 1'b0);

      // fill past capacity while the result side holds off
      hold_due = 1'b1;
      repeat (1050) send_item(CMD_INSERT, CHAR_W'($urandom_range(0, 255)),
                              INDEX_W'($urandom_range(0, 1023)));

      // work near full: moves, reads over the whole range, drops and deletes
      hold_due = 1'b1;
      repeat (375) send_random(15, 25, 20, 10, 28, 1'b1);
      req_bus.valid <= 1'b0;

      while (outstanding != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("cursor_line_edit_buffer_tb: PASS");
      else
         $display("cursor_line_edit_buffer_tb: FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/clb_pkg.sv
src/clb_if.sv
src/clb_ram.sv
src/cursor_line_edit_buffer.sv
dv/line_edit_checker.sv
dv/cursor_line_edit_buffer_tb.sv
